/* src/tcfs_pkg.sv */
package tcfs_pkg;

   localparam int MELODY_LENGTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT   = 2;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MELODY_VOLUME = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EFFECT_LENGTH = 1'b1;

   localparam logic [3:0] MELODY_VOLUME_RESET = 4'd10;
   localparam logic [3:0] EFFECT_LENGTH_RESET = 4'd8;

   localparam logic [2:0] CODE_NONE     = 3'd0;
   localparam logic [2:0] CODE_CORE_HIT = 3'd4;
   localparam logic [2:0] CODE_UNKNOWN  = 3'd7;

   localparam logic [3:0] REG_TONE_A_LO = 4'd0;
   localparam logic [3:0] REG_TONE_A_HI = 4'd1;
   localparam logic [3:0] REG_TONE_B_LO = 4'd2;
   localparam logic [3:0] REG_TONE_B_HI = 4'd3;
   localparam logic [3:0] REG_MIXER     = 4'd7;
   localparam logic [3:0] REG_VOLUME_A  = 4'd8;
   localparam logic [3:0] REG_VOLUME_B  = 4'd9;

   localparam logic [7:0] MIX_ALL_OFF = 8'h3F;
   localparam int MIX_TONE_A_BIT  = 0;
   localparam int MIX_TONE_B_BIT  = 1;
   localparam int MIX_NOISE_A_BIT = 3;

   // write slots of one tick, in emission order
   localparam int NUM_SLOTS = 8;
   localparam logic [2:0] SLOT_FX_LO   = 3'd0;
   localparam logic [2:0] SLOT_FX_HI   = 3'd1;
   localparam logic [2:0] SLOT_FX_VOL  = 3'd2;
   localparam logic [2:0] SLOT_FX_OFF  = 3'd3;
   localparam logic [2:0] SLOT_NOTE_LO = 3'd4;
   localparam logic [2:0] SLOT_NOTE_HI = 3'd5;
   localparam logic [2:0] SLOT_B_VOL   = 3'd6;
   localparam logic [2:0] SLOT_MIX     = 3'd7;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      logic [2:0]           code;
      logic [11:0]          period;
      logic [3:0]           b_vol;
      logic [7:0]           mix;
      logic [7:0]           count;
   } desc_type;

   function automatic logic [11:0] tune_period(input logic [3:0] slot);
      logic [11:0] p;
      unique case (slot)
         4'd0:    p = 12'd1008;
         4'd1:    p = 12'd1008;
         4'd2:    p = 12'd847;
         4'd3:    p = 12'd1008;
         4'd4:    p = 12'd0;
         4'd5:    p = 12'd1131;
         4'd6:    p = 12'd1008;
         4'd7:    p = 12'd1345;
         4'd8:    p = 12'd1269;
         4'd9:    p = 12'd1345;
         4'd10:   p = 12'd0;
         4'd11:   p = 12'd755;
         4'd12:   p = 12'd847;
         4'd13:   p = 12'd898;
         4'd14:   p = 12'd1008;
         default: p = 12'd1345;
      endcase
      return p;
   endfunction

   function automatic logic [4:0] tune_frames(input logic [3:0] slot);
      logic [4:0] f;
      unique case (slot)
         4'd1:    f = 5'd12;
         4'd2:    f = 5'd14;
         4'd4:    f = 5'd8;
         4'd5:    f = 5'd14;
         4'd8:    f = 5'd14;
         4'd10:   f = 5'd8;
         4'd11:   f = 5'd14;
         4'd12:   f = 5'd14;
         default: f = 5'd16;
      endcase
      return f;
   endfunction

   function automatic logic [7:0] fx_tone_lo(input logic [2:0] code);
      return (code == CODE_CORE_HIT) ? 8'h80 : 8'h00;
   endfunction

   function automatic logic [7:0] fx_tone_hi(input logic [2:0] code);
      logic [7:0] v;
      unique case (code)
         3'd1:    v = 8'h01;
         3'd2:    v = 8'h02;
         3'd3:    v = 8'h04;
         3'd4:    v = 8'h03;
         3'd5:    v = 8'h08;
         3'd6:    v = 8'h10;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [3:0] fx_volume(input logic [2:0] code);
      logic [3:0] v;
      unique case (code)
         3'd1:    v = 4'd8;
         3'd2:    v = 4'd12;
         3'd3:    v = 4'd10;
         3'd4:    v = 4'd14;
         3'd5:    v = 4'd15;
         3'd6:    v = 4'd15;
         default: v = 4'd0;
      endcase
      return v;
   endfunction

endpackage

/* src/tcfs_queue.sv */
module tcfs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

/* src/tcfs_front.sv */
module tcfs_front #(
   parameter int MELODY_LENGTH = tcfs_pkg::MELODY_LENGTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [2:0]                         req_effect_code,
   input  logic                               req_playing,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tcfs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tcfs_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                               q_push,
   output tcfs_pkg::desc_type                 q_data,
   input  logic                               q_full
);

   localparam int POS_W = (MELODY_LENGTH > 1) ? $clog2(MELODY_LENGTH) : 1;

   logic [3:0]       melody_volume_ff, melody_volume_in;
   logic [3:0]       effect_length_ff, effect_length_in;
   logic [2:0]       seen_effect_ff, seen_effect_in;
   logic [2:0]       active_effect_ff, active_effect_in;
   logic [3:0]       effect_frames_ff, effect_frames_in;
   logic [POS_W-1:0] note_position_ff, note_position_in;
   logic [4:0]       note_frames_ff, note_frames_in;
   logic [7:0]       note_advances_ff, note_advances_in;

   logic             accept, arm, fx_on, new_note, rest;
   logic [3:0]       frames_loaded;
   logic [POS_W+3:0] pos_ext;
   logic [3:0]       slot;
   logic [11:0]      period;
   logic [7:0]       mix;

   assign req_full  = q_full;
   assign csr_ready = 1'b1;
   assign accept    = req_push && !q_full;
   assign q_push    = accept;

   always_comb begin
      melody_volume_in = melody_volume_ff;
      effect_length_in = effect_length_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tcfs_pkg::CSR_MELODY_VOLUME: melody_volume_in = csr_data;
            tcfs_pkg::CSR_EFFECT_LENGTH: effect_length_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      seen_effect_in   = req_effect_code;
      arm              = (req_effect_code != seen_effect_ff)
                         && (req_effect_code != tcfs_pkg::CODE_NONE);
      active_effect_in = arm ? req_effect_code : active_effect_ff;
      frames_loaded    = arm ? effect_length_ff : effect_frames_ff;
      effect_frames_in = (frames_loaded != '0) ? frames_loaded - 1'b1 : '0;
      fx_on            = (effect_frames_in != '0);

      new_note         = req_playing && (note_frames_ff == '0);
      note_position_in = note_position_ff;
      note_advances_in = note_advances_ff;
      note_frames_in   = note_frames_ff;
      if (!req_playing) begin
         note_position_in = '0;
         note_frames_in   = '0;
      end else if (new_note) begin
         note_position_in = (note_position_ff == POS_W'(MELODY_LENGTH - 1))
                            ? '0 : note_position_ff + 1'b1;
         note_advances_in = note_advances_ff + 1'b1;
      end else begin
         note_frames_in = note_frames_ff - 1'b1;
      end
      pos_ext = (POS_W + 4)'(note_position_in);
      slot    = pos_ext[3:0];
      period  = tcfs_pkg::tune_period(slot);
      rest    = (period == '0);
      if (new_note) begin
         note_frames_in = tcfs_pkg::tune_frames(slot);
      end

      mix = tcfs_pkg::MIX_ALL_OFF;
      if (req_playing) begin
         mix[tcfs_pkg::MIX_TONE_B_BIT] = 1'b0;
      end
      if (fx_on) begin
         mix[tcfs_pkg::MIX_TONE_A_BIT] = 1'b0;
         if (active_effect_in == tcfs_pkg::CODE_CORE_HIT) begin
            mix[tcfs_pkg::MIX_NOISE_A_BIT] = 1'b0;
         end
      end

      q_data        = '0;
      q_data.code   = req_effect_code;
      q_data.period = period;
      q_data.b_vol  = (new_note && !rest) ? melody_volume_ff : '0;
      q_data.mix    = mix;
      q_data.count  = note_advances_in;
      q_data.mask[tcfs_pkg::SLOT_FX_LO]   = arm && (req_effect_code != tcfs_pkg::CODE_UNKNOWN);
      q_data.mask[tcfs_pkg::SLOT_FX_HI]   = arm && (req_effect_code != tcfs_pkg::CODE_UNKNOWN);
      q_data.mask[tcfs_pkg::SLOT_FX_VOL]  = arm && (req_effect_code != tcfs_pkg::CODE_UNKNOWN);
      q_data.mask[tcfs_pkg::SLOT_FX_OFF]  = (frames_loaded != '0) && !fx_on;
      q_data.mask[tcfs_pkg::SLOT_NOTE_LO] = new_note && !rest;
      q_data.mask[tcfs_pkg::SLOT_NOTE_HI] = new_note && !rest;
      q_data.mask[tcfs_pkg::SLOT_B_VOL]   = new_note || !req_playing;
      q_data.mask[tcfs_pkg::SLOT_MIX]     = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         melody_volume_ff <= tcfs_pkg::MELODY_VOLUME_RESET;
         effect_length_ff <= tcfs_pkg::EFFECT_LENGTH_RESET;
         seen_effect_ff   <= tcfs_pkg::CODE_NONE;
         active_effect_ff <= tcfs_pkg::CODE_NONE;
         effect_frames_ff <= '0;
         note_position_ff <= '0;
         note_frames_ff   <= '0;
         note_advances_ff <= '0;
      end else begin
         melody_volume_ff <= melody_volume_in;
         effect_length_ff <= effect_length_in;
         if (accept) begin
            seen_effect_ff   <= seen_effect_in;
            active_effect_ff <= active_effect_in;
            effect_frames_ff <= effect_frames_in;
            note_position_ff <= note_position_in;
            note_frames_ff   <= note_frames_in;
            note_advances_ff <= note_advances_in;
         end
      end
   end

   a_note_timer: assert property (@(posedge clock) disable iff (reset)
      accept && !req_playing |=> note_frames_ff == '0 && note_position_ff == '0)
      else $error("melody not reset when stopped");

endmodule

/* src/tcfs_back.sv */
module tcfs_back (
   input  logic               clock,
   input  logic               reset,
   input  tcfs_pkg::desc_type q_head,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [3:0]         rsp_reg_index,
   output logic [7:0]         rsp_reg_value,
   output logic               rsp_last_write,
   output logic [7:0]         rsp_note_count
);

   tcfs_pkg::desc_type cur_ff, cur_in;
   logic [tcfs_pkg::NUM_SLOTS-1:0] rem_ff, rem_in, rem_after;
   logic       out_valid_ff, out_valid_in;
   logic [3:0] out_index_ff;
   logic [7:0] out_value_ff, out_count_ff;
   logic       out_last_ff;
   logic       advance, emit, load;
   logic [2:0] idx;
   logic [3:0] sel_index;
   logic [7:0] sel_value;

   assign rsp_empty      = !out_valid_ff;
   assign rsp_reg_index  = out_index_ff;
   assign rsp_reg_value  = out_value_ff;
   assign rsp_last_write = out_last_ff;
   assign rsp_note_count = out_count_ff;

   always_comb begin
      idx = '0;
      for (int i = tcfs_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            idx = 3'(i);
         end
      end
   end

   always_comb begin
      unique case (idx)
         tcfs_pkg::SLOT_FX_LO: begin
            sel_index = tcfs_pkg::REG_TONE_A_LO;
            sel_value = tcfs_pkg::fx_tone_lo(cur_ff.code);
         end
         tcfs_pkg::SLOT_FX_HI: begin
            sel_index = tcfs_pkg::REG_TONE_A_HI;
            sel_value = tcfs_pkg::fx_tone_hi(cur_ff.code);
         end
         tcfs_pkg::SLOT_FX_VOL: begin
            sel_index = tcfs_pkg::REG_VOLUME_A;
            sel_value = {4'd0, tcfs_pkg::fx_volume(cur_ff.code)};
         end
         tcfs_pkg::SLOT_FX_OFF: begin
            sel_index = tcfs_pkg::REG_VOLUME_A;
            sel_value = 8'd0;
         end
         tcfs_pkg::SLOT_NOTE_LO: begin
            sel_index = tcfs_pkg::REG_TONE_B_LO;
            sel_value = cur_ff.period[7:0];
         end
         tcfs_pkg::SLOT_NOTE_HI: begin
            sel_index = tcfs_pkg::REG_TONE_B_HI;
            sel_value = {4'd0, cur_ff.period[11:8]};
         end
         tcfs_pkg::SLOT_B_VOL: begin
            sel_index = tcfs_pkg::REG_VOLUME_B;
            sel_value = {4'd0, cur_ff.b_vol};
         end
         default: begin
            sel_index = tcfs_pkg::REG_MIXER;
            sel_value = cur_ff.mix;
         end
      endcase
   end

   always_comb begin
      advance      = !out_valid_ff || rsp_pop;
      emit         = advance && (rem_ff != '0);
      rem_after    = emit ? (rem_ff & ~(tcfs_pkg::NUM_SLOTS'(1) << idx)) : rem_ff;
      load         = (rem_after == '0) && !q_empty;
      q_pop        = load;
      rem_in       = load ? q_head.mask : rem_after;
      cur_in       = load ? q_head : cur_ff;
      out_valid_in = advance ? (rem_ff != '0) : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         out_index_ff <= sel_index;
         out_value_ff <= sel_value;
         out_last_ff  <= (rem_after == '0);
         out_count_ff <= cur_ff.count;
      end
   end

   a_last_is_mixer: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last_write |-> rsp_reg_index == tcfs_pkg::REG_MIXER)
      else $error("last write of a tick is not the mixer");

   a_load_has_mixer: assert property (@(posedge clock) disable iff (reset)
      load |-> q_head.mask[tcfs_pkg::SLOT_MIX])
      else $error("tick descriptor without mixer write");

   a_mixer_ends_tick: assert property (@(posedge clock) disable iff (reset)
      emit && idx == tcfs_pkg::SLOT_MIX |=> out_last_ff)
      else $error("mixer write not marked last");

endmodule

/* src/tone_chip_frame_sequencer.sv */
// Tone chip frame sequencer.
// Input queue port: drive req_effect_code and req_playing with req_push once per
// frame tick; the tick transfers on a clock edge where req_push is high and
// req_full is low.
// Output queue port: each tick yields one to eight chip register writes
// (rsp_reg_index, rsp_reg_value, rsp_note_count), ending with the mixer write
// flagged by rsp_last_write. A write is shown while rsp_empty is low and
// transfers on an edge where rsp_pop is high.
// Config port: csr_index/csr_data written when csr_valid is high (csr_ready is
// always high); write only while no tick is in flight.
// A tick waits in the tick queue, then in the back end's descriptor register;
// each write is registered at the output. The output stage emits one write
// per cycle while rsp_pop is high or no write is shown; a QUEUE_DEPTH-entry
// tick queue (two by default) lets the input keep transferring meanwhile.
// A stalled output holds its write and fills the tick queue; req_full rises
// when the queue is full. Reset empties all queues and clears effect and
// melody state, restoring melody volume 10 and effect length 8.
module tone_chip_frame_sequencer #(
   parameter int MELODY_LENGTH = tcfs_pkg::MELODY_LENGTH_DEFAULT,
   parameter int QUEUE_DEPTH   = tcfs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [2:0]                       req_effect_code,
   input  logic                             req_playing,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [3:0]                       rsp_reg_index,
   output logic [7:0]                       rsp_reg_value,
   output logic                             rsp_last_write,
   output logic [7:0]                       rsp_note_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tcfs_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int DESC_W = $bits(tcfs_pkg::desc_type);

   tcfs_pkg::desc_type push_desc, head_desc;
   logic [DESC_W-1:0]  head_bits;
   logic               q_push, q_full, q_pop, q_empty;

   assign head_desc = tcfs_pkg::desc_type'(head_bits);

   tcfs_front #(
      .MELODY_LENGTH (MELODY_LENGTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_effect_code (req_effect_code),
      .req_playing     (req_playing),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .q_push          (q_push),
      .q_data          (push_desc),
      .q_full          (q_full)
   );

   tcfs_queue #(
      .WIDTH (DESC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (DESC_W'(push_desc)),
      .full      (q_full),
      .pop       (q_pop),
      .head      (head_bits),
      .empty     (q_empty)
   );

   tcfs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_head         (head_desc),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_reg_index  (rsp_reg_index),
      .rsp_reg_value  (rsp_reg_value),
      .rsp_last_write (rsp_last_write),
      .rsp_note_count (rsp_note_count)
   );

endmodule
